// ===== hw/rtl/time_versioned_key_value_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the time-versioned key-value table unit
// Clocked implication checks used by the datapath, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TIME_VERSIONED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define TIME_VERSIONED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVKV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvkv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TVKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvkv assertion failed");

`endif

// ===== hw/rtl/tvkv_pkg.sv =====
// ----------------------------------------------------------------------------
// tvkv_pkg
// Types and constants shared by the time-versioned key-value table unit.
// ----------------------------------------------------------------------------
package tvkv_pkg;

  localparam int KEY_W    = 16;
  localparam int VALUE_W  = 32;
  localparam int STAMP_W  = 31;
  localparam int STATUS_W = 2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_FOUND   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POST
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    write;
    logic    scan_start;
    logic    scan_step;
    logic    set_result;
    status_t result_kind;
    logic    post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic full;
    logic empty;
    logic hit;
    logic last_miss;
    logic slot_free;
  } stat_t;

endpackage

// ===== hw/rtl/tvkv_req_if.sv =====
// ----------------------------------------------------------------------------
// tvkv_req_if
// Request channel: one store or query item per transaction.
// ----------------------------------------------------------------------------
interface tvkv_req_if
  import tvkv_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [KEY_W-1:0]   key_id;
  logic [VALUE_W-1:0] value_id;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, output op, output key_id, output value_id,
                  output stamp, input ready);
  modport sink   (input valid, input op, input key_id, input value_id,
                  input stamp, output ready);
endinterface

// ===== hw/rtl/tvkv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tvkv_rsp_if
// Response channel: one status and value per transaction.
// ----------------------------------------------------------------------------
interface tvkv_rsp_if
  import tvkv_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

// ===== hw/rtl/tvkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvkv_ctrl
// Controller state machine: sequences store, scan and result posting.
// ----------------------------------------------------------------------------
module tvkv_ctrl
  import tvkv_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_query && !stat.empty) state_next = S_SCAN;
        else state_next = S_POST;
      end
      S_SCAN: begin
        if (stat.hit || stat.last_miss) state_next = S_POST;
      end
      S_POST: begin
        if (stat.slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.result_kind = ST_MISSING;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        if (!stat.is_query) begin
          cmd.set_result  = 1'b1;
          cmd.write       = !stat.full;
          cmd.result_kind = stat.full ? ST_FULL : ST_STORED;
        end else if (stat.empty) begin
          cmd.set_result  = 1'b1;
          cmd.result_kind = ST_MISSING;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.set_result  = 1'b1;
          cmd.result_kind = ST_FOUND;
        end else if (stat.last_miss) begin
          cmd.set_result  = 1'b1;
          cmd.result_kind = ST_MISSING;
        end
      end
      S_POST: begin
        cmd.post = stat.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tvkv_dp.sv =====
// ----------------------------------------------------------------------------
// tvkv_dp
// Datapath: item registers, entry memory, fill count, scan pointer,
// match logic and the output register.
// ----------------------------------------------------------------------------
`include "time_versioned_key_value_table_unit_assert.svh"

module tvkv_dp
  import tvkv_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
)(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                in_op,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [STAMP_W-1:0]  in_stamp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [VALUE_W-1:0]  out_value
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic [STAMP_W-1:0] stamp_q;

  entry_t mem [TABLE_DEPTH];

  logic [CW-1:0] count;
  logic [IW-1:0] ptr;
  logic          more;
  entry_t        rd_q;
  logic          rd_v;
  logic          rd_last;

  status_t            pend_status;
  logic [VALUE_W-1:0] pend_value;
  logic               res_valid;
  status_t            res_status;
  logic [VALUE_W-1:0] res_value;

  logic full;
  logic match;

  assign full  = (count == CW'(TABLE_DEPTH));
  assign match = rd_v && (rd_q.key == key_q) && (rd_q.stamp <= stamp_q);

  always_comb begin
    stat.is_query  = (op_q == OP_QUERY);
    stat.full      = full;
    stat.empty     = (count == '0);
    stat.hit       = match;
    stat.last_miss = rd_v && rd_last && !match;
    stat.slot_free = !res_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= in_op;
      key_q   <= in_key;
      value_q <= in_value;
      stamp_q <= in_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[count[IW-1:0]] <= '{key: key_q, stamp: stamp_q, value: value_q};
    end
    if (cmd.scan_step && more) begin
      rd_q <= mem[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ptr     <= '0;
      more    <= 1'b0;
      rd_v    <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      if (cmd.write) count <= count + CW'(1);
      if (cmd.scan_start) begin
        ptr  <= IW'(count - CW'(1));
        more <= 1'b1;
        rd_v <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_v <= more;
        if (more) begin
          // The oldest entry sits at index zero, so the scan ends there.
          rd_last <= (ptr == '0);
          more    <= (ptr != '0);
          ptr     <= ptr - IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      pend_status <= cmd.result_kind;
      pend_value  <= (cmd.result_kind == ST_FOUND) ? rd_q.value : '0;
    end
    if (cmd.post) begin
      res_status <= pend_status;
      res_value  <= pend_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.post) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  assign out_valid  = res_valid;
  assign out_status = res_status;
  assign out_value  = res_value;

  `TVKV_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CW'(TABLE_DEPTH))
  `TVKV_ASSERT_SAME(a_write_not_full, clk, rst, cmd.write, !full)
  `TVKV_ASSERT_NEXT(a_post_shows, clk, rst, cmd.post, res_valid)
  `TVKV_ASSERT_NEXT(a_read_lands, clk, rst, cmd.scan_step && more, rd_v)

endmodule

// ===== hw/rtl/time_versioned_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// time_versioned_key_value_table_unit
// Append-only key/value/timestamp table with newest-at-or-before lookup.
// ----------------------------------------------------------------------------
// A store appends one entry and answers stored, or full when the table
// already holds TABLE_DEPTH entries. A query scans the entries from newest
// to oldest and answers the value of the first entry with the same key and
// a stamp at most the target, or not found. The entries live in a single
// memory with one write and one registered read port, and the scan reads
// one entry per cycle through that read port. A store passes through the
// accept, execute and post states; a query on a nonempty table adds the
// scan state between execute and post. One item is worked on at a time;
// a new request is taken while the previous response still waits in the
// output register. There is no clearing pass after reset; only entries
// already written are ever read.
// ----------------------------------------------------------------------------
module time_versioned_key_value_table_unit
  import tvkv_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
)(
  input logic          clk,
  input logic          rst,
  tvkv_req_if.sink     req,
  tvkv_rsp_if.source   rsp
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  tvkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tvkv_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (req.op),
    .in_key     (req.key_id),
    .in_value   (req.value_id),
    .in_stamp   (req.stamp),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_value  (rsp.found_value)
  );

  assign req.ready = in_ready;

endmodule
